// ===== rtl/vertex_normal_accumulator_unit_defines.svh =====
// Assertion macros for the vertex normal accumulator checker.
// Depends on nothing; the using scope supplies clk and arst_n.
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_DEFINES_SVH

// Condition in this cycle implies the consequence in the next cycle.
`define VNACC_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

// Condition in this cycle implies the consequence in the same cycle.
`define VNACC_ASSERT_SAME(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/vnacc_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the vertex normal accumulator. Depends on nothing.
package vnacc_pkg;

	localparam int VERTEX_COUNT = 1024;
	localparam int COORD_BITS   = 16;
	localparam int ACCUM_BITS   = 48;

	localparam int IDX_BITS   = 10;
	localparam int OP_BITS    = 2;
	localparam int ADDR_BITS  = $clog2(VERTEX_COUNT);
	localparam int CMP_BITS   = 32;
	localparam int EDGE_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * EDGE_BITS;
	localparam int CROSS_BITS = PROD_BITS + 1;
	localparam int SUM_BITS   = ((ACCUM_BITS > CROSS_BITS) ? ACCUM_BITS : CROSS_BITS) + 1;
	localparam int VTX_WIDTH  = 3 * COORD_BITS;
	localparam int ACC_WIDTH  = 3 * ACCUM_BITS;

	localparam logic signed [ACCUM_BITS-1:0] ACC_MAX = {1'b0, {(ACCUM_BITS-1){1'b1}}};
	localparam logic signed [ACCUM_BITS-1:0] ACC_MIN = {1'b1, {(ACCUM_BITS-1){1'b0}}};

	typedef enum logic [OP_BITS-1:0] {
		OP_LOAD = 2'd0,
		OP_TRI  = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SEL_A = 2'd0,
		SEL_B = 2'd1,
		SEL_C = 2'd2
	} sel_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_VTX_A,
		ST_VTX_B,
		ST_VTX_C,
		ST_EDGE,
		ST_MUL,
		ST_CROSS,
		ST_ACC_RA,
		ST_ACC_WA,
		ST_ACC_WB,
		ST_ACC_WC,
		ST_RD_REQ,
		ST_RD_DATA
	} state_t;

	typedef struct packed {
		logic capture;
		logic vtx_we;
		logic vtx_re;
		sel_t vtx_sel;
		logic pa_ld;
		logic pb_ld;
		logic edge_ld;
		logic mul_ld;
		logic cross_ld;
		logic acc_re;
		sel_t acc_rsel;
		logic acc_we;
		sel_t acc_wsel;
		logic clr_we;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic ld_ok;
		logic tri_ok;
		logic clr_last;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/vertex_normal_accumulator_unit.sv =====
// Top level of the area-weighted vertex normal accumulator.
// Depends on vnacc_pkg, vnacc_ctrl and vnacc_datapath.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   input    | in_valid / in_stall | op, index_a, index_b, index_c, pos_x/y/z
//   output   | out_valid/out_stall | normal_x, normal_y, normal_z
//
// One beat is in work at a time. A load or an unused op completes in the idle
// state; a triangle steps through three vertex reads, edge, multiply and cross
// stages, then three read-modify-writes that share the accumulator write port.
// A readout reads in ST_RD_REQ and loads the output register in ST_RD_DATA once
// it is free; the next beat may enter while that result waits to be taken.
// After reset a sweep zeroes all 1024 accumulators with in_stall high.
module vertex_normal_accumulator_unit import vnacc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [OP_BITS-1:0]           op,
	input  logic [IDX_BITS-1:0]          index_a,
	input  logic [IDX_BITS-1:0]          index_b,
	input  logic [IDX_BITS-1:0]          index_c,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [ACCUM_BITS-1:0] normal_x,
	output logic signed [ACCUM_BITS-1:0] normal_y,
	output logic signed [ACCUM_BITS-1:0] normal_z
);

	cmd_t  cmd;
	stat_t status;

	vnacc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.op      (op),
		.status  (status),
		.in_stall(in_stall),
		.cmd     (cmd)
	);

	vnacc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.index_a  (index_a),
		.index_b  (index_b),
		.index_c  (index_c),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z)
	);

endmodule

// ===== rtl/vnacc_ram.sv =====
// Generic memory with one write port and one registered read port.
// A read of the address written in the same cycle returns the old data.
module vnacc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/vnacc_ctrl.sv =====
// Sequencing controller of the vertex normal accumulator.
// Depends on vnacc_pkg for the state, op, command and status types.
module vnacc_ctrl import vnacc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [OP_BITS-1:0] op,
	input  stat_t              status,
	output logic               in_stall,
	output cmd_t               cmd
);

	state_t state_q;
	state_t state_n;
	op_t    op_e;

	assign op_e = op_t'(op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clr_last) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					unique case (op_e) inside
						OP_LOAD, OP_NONE: state_n = ST_IDLE;
						OP_TRI:           state_n = status.tri_ok ? ST_VTX_A : ST_IDLE;
						OP_READ:          state_n = ST_RD_REQ;
						default:          state_n = ST_IDLE;
					endcase
				end
			end
			ST_VTX_A:   state_n = ST_VTX_B;
			ST_VTX_B:   state_n = ST_VTX_C;
			ST_VTX_C:   state_n = ST_EDGE;
			ST_EDGE:    state_n = ST_MUL;
			ST_MUL:     state_n = ST_CROSS;
			ST_CROSS:   state_n = ST_ACC_RA;
			ST_ACC_RA:  state_n = ST_ACC_WA;
			ST_ACC_WA:  state_n = ST_ACC_WB;
			ST_ACC_WB:  state_n = ST_ACC_WC;
			ST_ACC_WC:  state_n = ST_IDLE;
			ST_RD_REQ:  state_n = ST_RD_DATA;
			ST_RD_DATA: begin
				if (status.out_free) begin
					state_n = ST_IDLE;
				end
			end
			default:    state_n = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.vtx_we  = (op_e == OP_LOAD) && status.ld_ok;
				end
			end
			ST_VTX_A: begin
				cmd.vtx_re  = 1'b1;
				cmd.vtx_sel = SEL_A;
			end
			ST_VTX_B: begin
				cmd.vtx_re  = 1'b1;
				cmd.vtx_sel = SEL_B;
				cmd.pa_ld   = 1'b1;
			end
			ST_VTX_C: begin
				cmd.vtx_re  = 1'b1;
				cmd.vtx_sel = SEL_C;
				cmd.pb_ld   = 1'b1;
			end
			ST_EDGE:  cmd.edge_ld  = 1'b1;
			ST_MUL:   cmd.mul_ld   = 1'b1;
			ST_CROSS: cmd.cross_ld = 1'b1;
			ST_ACC_RA: begin
				cmd.acc_re   = 1'b1;
				cmd.acc_rsel = SEL_A;
			end
			ST_ACC_WA: begin
				cmd.acc_we   = 1'b1;
				cmd.acc_wsel = SEL_A;
				cmd.acc_re   = 1'b1;
				cmd.acc_rsel = SEL_B;
			end
			ST_ACC_WB: begin
				cmd.acc_we   = 1'b1;
				cmd.acc_wsel = SEL_B;
				cmd.acc_re   = 1'b1;
				cmd.acc_rsel = SEL_C;
			end
			ST_ACC_WC: begin
				cmd.acc_we   = 1'b1;
				cmd.acc_wsel = SEL_C;
			end
			ST_RD_REQ: begin
				cmd.acc_re   = 1'b1;
				cmd.acc_rsel = SEL_A;
			end
			ST_RD_DATA: begin
				cmd.out_ld = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/vnacc_datapath.sv =====
// Datapath: vertex and accumulator memories, edge and cross product
// registers, saturating update and the output register. Depends on vnacc_pkg, vnacc_ram.
module vnacc_datapath import vnacc_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cmd_t                         cmd,
	output stat_t                        status,
	input  logic [IDX_BITS-1:0]          index_a,
	input  logic [IDX_BITS-1:0]          index_b,
	input  logic [IDX_BITS-1:0]          index_c,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic                         out_stall,
	output logic                         out_valid,
	output logic signed [ACCUM_BITS-1:0] normal_x,
	output logic signed [ACCUM_BITS-1:0] normal_y,
	output logic signed [ACCUM_BITS-1:0] normal_z
);

	function automatic logic idx_ok(input logic [IDX_BITS-1:0] i);
		return CMP_BITS'(i) < CMP_BITS'(VERTEX_COUNT);
	endfunction

	function automatic logic signed [ACCUM_BITS-1:0] sat_add(
		input logic signed [ACCUM_BITS-1:0] a,
		input logic signed [CROSS_BITS-1:0] b
	);
		logic signed [SUM_BITS-1:0] s;
		s = SUM_BITS'(a) + SUM_BITS'(b);
		if (s > SUM_BITS'(ACC_MAX)) begin
			return ACC_MAX;
		end else if (s < SUM_BITS'(ACC_MIN)) begin
			return ACC_MIN;
		end
		return s[ACCUM_BITS-1:0];
	endfunction

	logic [IDX_BITS-1:0] idx_a_q;
	logic [IDX_BITS-1:0] idx_b_q;
	logic [IDX_BITS-1:0] idx_c_q;
	logic                rd_ok_q;

	logic [IDX_BITS-1:0]  vtx_idx;
	logic [VTX_WIDTH-1:0] vtx_rdata;

	logic signed [COORD_BITS-1:0] vx;
	logic signed [COORD_BITS-1:0] vy;
	logic signed [COORD_BITS-1:0] vz;
	logic signed [COORD_BITS-1:0] pax_q, pay_q, paz_q;
	logic signed [COORD_BITS-1:0] pbx_q, pby_q, pbz_q;
	logic signed [EDGE_BITS-1:0]  abx_q, aby_q, abz_q;
	logic signed [EDGE_BITS-1:0]  acx_q, acy_q, acz_q;
	logic signed [PROD_BITS-1:0]  p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
	logic signed [CROSS_BITS-1:0] nx_q, ny_q, nz_q;

	logic [IDX_BITS-1:0]  acc_ridx;
	logic [IDX_BITS-1:0]  acc_widx;
	logic [ADDR_BITS-1:0] acc_raddr;
	logic [ADDR_BITS-1:0] acc_waddr;
	logic [ACC_WIDTH-1:0] acc_wdata;
	logic [ACC_WIDTH-1:0] acc_rdata;
	logic [ACC_WIDTH-1:0] acc_old;
	logic [ACC_WIDTH-1:0] byp_q;
	logic                 byp_hit_q;
	logic [ADDR_BITS-1:0] clr_cnt_q;

	logic signed [ACCUM_BITS-1:0] old_x, old_y, old_z;
	logic signed [ACCUM_BITS-1:0] normal_x_q, normal_y_q, normal_z_q;
	logic                         out_valid_q;

	assign status.ld_ok    = idx_ok(index_a);
	assign status.tri_ok   = idx_ok(index_a) && idx_ok(index_b) && idx_ok(index_c);
	assign status.clr_last = (clr_cnt_q == ADDR_BITS'(VERTEX_COUNT - 1));
	assign status.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_a_q <= index_a;
			idx_b_q <= index_b;
			idx_c_q <= index_c;
			rd_ok_q <= idx_ok(index_a);
		end
	end

	// Vertex store: written straight from the input beat of a load.
	always_comb begin
		case (cmd.vtx_sel)
			SEL_A:   vtx_idx = idx_a_q;
			SEL_B:   vtx_idx = idx_b_q;
			SEL_C:   vtx_idx = idx_c_q;
			default: vtx_idx = idx_a_q;
		endcase
	end

	vnacc_ram #(
		.WIDTH(VTX_WIDTH),
		.DEPTH(VERTEX_COUNT)
	) u_vtx_ram (
		.clk  (clk),
		.we   (cmd.vtx_we),
		.waddr(ADDR_BITS'(index_a)),
		.wdata({pos_x, pos_y, pos_z}),
		.re   (cmd.vtx_re),
		.raddr(ADDR_BITS'(vtx_idx)),
		.rdata(vtx_rdata)
	);

	assign vx = vtx_rdata[3*COORD_BITS-1:2*COORD_BITS];
	assign vy = vtx_rdata[2*COORD_BITS-1:COORD_BITS];
	assign vz = vtx_rdata[COORD_BITS-1:0];

	always_ff @(posedge clk) begin
		if (cmd.pa_ld) begin
			pax_q <= vx;
			pay_q <= vy;
			paz_q <= vz;
		end
		if (cmd.pb_ld) begin
			pbx_q <= vx;
			pby_q <= vy;
			pbz_q <= vz;
		end
		if (cmd.edge_ld) begin
			abx_q <= EDGE_BITS'(pbx_q) - EDGE_BITS'(pax_q);
			aby_q <= EDGE_BITS'(pby_q) - EDGE_BITS'(pay_q);
			abz_q <= EDGE_BITS'(pbz_q) - EDGE_BITS'(paz_q);
			acx_q <= EDGE_BITS'(vx) - EDGE_BITS'(pax_q);
			acy_q <= EDGE_BITS'(vy) - EDGE_BITS'(pay_q);
			acz_q <= EDGE_BITS'(vz) - EDGE_BITS'(paz_q);
		end
		if (cmd.mul_ld) begin
			p0_q <= aby_q * acz_q;
			p1_q <= abz_q * acy_q;
			p2_q <= abz_q * acx_q;
			p3_q <= abx_q * acz_q;
			p4_q <= abx_q * acy_q;
			p5_q <= aby_q * acx_q;
		end
		if (cmd.cross_ld) begin
			nx_q <= CROSS_BITS'(p0_q) - CROSS_BITS'(p1_q);
			ny_q <= CROSS_BITS'(p2_q) - CROSS_BITS'(p3_q);
			nz_q <= CROSS_BITS'(p4_q) - CROSS_BITS'(p5_q);
		end
	end

	// Accumulator store: the reset sweep and the three updates share the write port.
	always_comb begin
		case (cmd.acc_rsel)
			SEL_A:   acc_ridx = idx_a_q;
			SEL_B:   acc_ridx = idx_b_q;
			SEL_C:   acc_ridx = idx_c_q;
			default: acc_ridx = idx_a_q;
		endcase
		case (cmd.acc_wsel)
			SEL_A:   acc_widx = idx_a_q;
			SEL_B:   acc_widx = idx_b_q;
			SEL_C:   acc_widx = idx_c_q;
			default: acc_widx = idx_a_q;
		endcase
	end

	assign acc_raddr = ADDR_BITS'(acc_ridx);
	assign acc_waddr = cmd.clr_we ? clr_cnt_q : ADDR_BITS'(acc_widx);

	// When a corner repeats, the read issued in the cycle of the previous write
	// returns stale data, so the written word is forwarded instead.
	assign acc_old = byp_hit_q ? byp_q : acc_rdata;
	assign old_x   = acc_old[3*ACCUM_BITS-1:2*ACCUM_BITS];
	assign old_y   = acc_old[2*ACCUM_BITS-1:ACCUM_BITS];
	assign old_z   = acc_old[ACCUM_BITS-1:0];

	assign acc_wdata = cmd.clr_we ? '0 :
		{sat_add(old_x, nx_q), sat_add(old_y, ny_q), sat_add(old_z, nz_q)};

	vnacc_ram #(
		.WIDTH(ACC_WIDTH),
		.DEPTH(VERTEX_COUNT)
	) u_acc_ram (
		.clk  (clk),
		.we   (cmd.acc_we || cmd.clr_we),
		.waddr(acc_waddr),
		.wdata(acc_wdata),
		.re   (cmd.acc_re),
		.raddr(acc_raddr),
		.rdata(acc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_hit_q <= 1'b0;
			clr_cnt_q <= '0;
		end else begin
			if (cmd.acc_re) begin
				byp_hit_q <= cmd.acc_we && (acc_raddr == acc_waddr);
			end
			if (cmd.clr_we) begin
				clr_cnt_q <= clr_cnt_q + ADDR_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_re) begin
			byp_q <= acc_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			normal_x_q <= rd_ok_q ? old_x : '0;
			normal_y_q <= rd_ok_q ? old_y : '0;
			normal_z_q <= rd_ok_q ? old_z : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign normal_x  = normal_x_q;
	assign normal_y  = normal_y_q;
	assign normal_z  = normal_z_q;

endmodule

// ===== rtl/vnacc_checker.sv =====
// Port-level assertions for the vertex normal accumulator, bound to the top.
// Depends on vnacc_pkg and vertex_normal_accumulator_unit_defines.svh.
`include "vertex_normal_accumulator_unit_defines.svh"

module vnacc_checker import vnacc_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [OP_BITS-1:0]           op,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [ACCUM_BITS-1:0] normal_x,
	input logic signed [ACCUM_BITS-1:0] normal_y,
	input logic signed [ACCUM_BITS-1:0] normal_z
);

	logic in_beat;

	assign in_beat = in_valid && !in_stall;

	// A stalled result stays put.
	`VNACC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(normal_x) && $stable(normal_y) && $stable(normal_z), "stalled result changed")

	// A readout occupies the block until its result is registered.
	`VNACC_ASSERT_NEXT(a_read_busy, in_beat && (op == OP_READ), in_stall, "beat taken during a readout")

	// A load finishes in its own cycle.
	`VNACC_ASSERT_NEXT(a_load_done, in_beat && (op == OP_LOAD), !in_stall, "load held the input")

	// A fresh result appears only in answer to a readout beat.
	`VNACC_ASSERT_SAME(a_result_src, $rose(out_valid), $past(in_beat && (op == OP_READ), 3), "result without readout")

endmodule

bind vertex_normal_accumulator_unit vnacc_checker u_checker (.*);

// ===== tb/tb_vertex_normal_accumulator_unit.sv =====
// Self-checking testbench for vertex_normal_accumulator_unit: loads, triangles, readouts and
// large accumulator sums, checked against an in-bench mesh predictor. Depends on vnacc_pkg.
`timescale 1ns / 1ps

module tb_vertex_normal_accumulator_unit import vnacc_pkg::*; ();

	localparam int CYCLE_LIMIT  = 4_000_000;
	localparam int RANDOM_BEATS = 1200;
	localparam int CALM_BEATS   = 200;
	localparam int BIG_ROUNDS   = 100;
	localparam int BIG_BASE     = 1000;
	localparam int DRAIN_CYCLES = 32;

	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

	typedef struct {
		logic signed [ACCUM_BITS-1:0] x;
		logic signed [ACCUM_BITS-1:0] y;
		logic signed [ACCUM_BITS-1:0] z;
	} normal_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid;
	logic                         in_stall;
	logic [OP_BITS-1:0]           op;
	logic [IDX_BITS-1:0]          index_a;
	logic [IDX_BITS-1:0]          index_b;
	logic [IDX_BITS-1:0]          index_c;
	logic signed [COORD_BITS-1:0] pos_x;
	logic signed [COORD_BITS-1:0] pos_y;
	logic signed [COORD_BITS-1:0] pos_z;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic signed [ACCUM_BITS-1:0] normal_x;
	logic signed [ACCUM_BITS-1:0] normal_y;
	logic signed [ACCUM_BITS-1:0] normal_z;

	// Mirror of the mesh: stored positions and running normal sums.
	logic signed [COORD_BITS-1:0] mesh_x [VERTEX_COUNT];
	logic signed [COORD_BITS-1:0] mesh_y [VERTEX_COUNT];
	logic signed [COORD_BITS-1:0] mesh_z [VERTEX_COUNT];
	logic signed [ACCUM_BITS-1:0] sum_x [VERTEX_COUNT];
	logic signed [ACCUM_BITS-1:0] sum_y [VERTEX_COUNT];
	logic signed [ACCUM_BITS-1:0] sum_z [VERTEX_COUNT];
	bit                           vertex_loaded [VERTEX_COUNT];
	int                           loaded_list [$];
	normal_t                      pending_normals [$];

	int          idle_pct = 0;
	int          stall_pct = 0;
	int          failures = 0;
	int unsigned cycle_count = 0;

	vertex_normal_accumulator_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.index_a  (index_a),
		.index_b  (index_b),
		.index_c  (index_c),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic signed [ACCUM_BITS-1:0] clamp_add(
			logic signed [ACCUM_BITS-1:0] acc, longint delta);
		longint total;
		total = acc;
		total += delta;
		if (total > longint'(ACC_MAX))
			return ACC_MAX;
		if (total < longint'(ACC_MIN))
			return ACC_MIN;
		return total[ACCUM_BITS-1:0];
	endfunction

	function automatic void add_to_vertex(int idx, longint nx, longint ny, longint nz);
		sum_x[idx] = clamp_add(sum_x[idx], nx);
		sum_y[idx] = clamp_add(sum_y[idx], ny);
		sum_z[idx] = clamp_add(sum_z[idx], nz);
	endfunction

	// Updates the mirror for one accepted beat and queues the readout it causes.
	function automatic void apply_beat(op_t kind, logic [IDX_BITS-1:0] ia, ib, ic,
			logic signed [COORD_BITS-1:0] px, py, pz);
		longint abx, aby, abz, acx, acy, acz;
		longint nx, ny, nz;
		normal_t res;
		case (kind)
			OP_LOAD: begin
				mesh_x[ia] = px;
				mesh_y[ia] = py;
				mesh_z[ia] = pz;
				if (!vertex_loaded[ia]) begin
					vertex_loaded[ia] = 1'b1;
					loaded_list.push_back(ia);
				end
			end
			OP_TRI: begin
				abx = mesh_x[ib]; abx -= mesh_x[ia];
				aby = mesh_y[ib]; aby -= mesh_y[ia];
				abz = mesh_z[ib]; abz -= mesh_z[ia];
				acx = mesh_x[ic]; acx -= mesh_x[ia];
				acy = mesh_y[ic]; acy -= mesh_y[ia];
				acz = mesh_z[ic]; acz -= mesh_z[ia];
				nx = aby * acz - abz * acy;
				ny = abz * acx - abx * acz;
				nz = abx * acy - aby * acx;
				// Corners are summed in order, so a repeated index adds twice.
				add_to_vertex(ia, nx, ny, nz);
				add_to_vertex(ib, nx, ny, nz);
				add_to_vertex(ic, nx, ny, nz);
			end
			OP_READ: begin
				res.x = sum_x[ia];
				res.y = sum_y[ia];
				res.z = sum_z[ia];
				pending_normals.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic logic [IDX_BITS-1:0] rand_index();
		logic [31:0] r;
		r = $urandom;
		return r[IDX_BITS-1:0];
	endfunction

	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		logic [31:0] r;
		int s;
		r = $urandom;
		case ($urandom_range(0, 4))
			0: begin
				case ($urandom_range(0, 3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			1: begin
				s = $urandom_range(0, 511);
				s -= 256;
				return s[COORD_BITS-1:0];
			end
			default: return r[COORD_BITS-1:0];
		endcase
	endfunction

	// Picks a loaded vertex, mostly from the current working window of the mesh.
	function automatic logic [IDX_BITS-1:0] pick_corner(int base);
		int idx;
		idx = base + $urandom_range(0, 15);
		if (!vertex_loaded[idx] || $urandom_range(0, 3) == 0)
			idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
		return idx[IDX_BITS-1:0];
	endfunction

	task automatic send_beat(op_t kind, logic [IDX_BITS-1:0] ia, ib, ic,
			logic signed [COORD_BITS-1:0] px, py, pz);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		index_a <= ia;
		index_b <= ib;
		index_c <= ic;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do @(posedge clk); while (in_stall !== 1'b0);
		apply_beat(kind, ia, ib, ic, px, py, pz);
	endtask

	task automatic send_load(int idx, logic signed [COORD_BITS-1:0] px, py, pz);
		send_beat(OP_LOAD, IDX_BITS'(idx), rand_index(), rand_index(), px, py, pz);
	endtask

	task automatic send_triangle(int ia, int ib, int ic);
		send_beat(OP_TRI, IDX_BITS'(ia), IDX_BITS'(ib), IDX_BITS'(ic), rand_coord(),
			rand_coord(), rand_coord());
	endtask

	task automatic send_read(int idx);
		send_beat(OP_READ, IDX_BITS'(idx), rand_index(), rand_index(), rand_coord(),
			rand_coord(), rand_coord());
	endtask

	task automatic send_unused();
		send_beat(OP_NONE, rand_index(), rand_index(), rand_index(), rand_coord(),
			rand_coord(), rand_coord());
	endtask

	// Accumulators must read back as zero straight after the clearing sweep.
	task automatic test_cleared_state();
		idle_pct = 20;
		stall_pct = 20;
		send_read(0);
		send_read(VERTEX_COUNT - 1);
		send_unused();
		send_read(341);
	endtask

	task automatic test_corner_mesh();
		send_load(0, COORD_MIN, COORD_MAX, '0);
		send_load(VERTEX_COUNT - 1, COORD_MAX, COORD_MIN, '1);
		send_load(512, COORD_MIN, COORD_MIN, COORD_MIN);
		send_load(341, COORD_MAX, COORD_MAX, COORD_MAX);
		send_triangle(0, VERTEX_COUNT - 1, 512);
		send_triangle(VERTEX_COUNT - 1, 512, 341);
		send_triangle(0, 0, 341);
		send_triangle(341, 512, 341);
		send_triangle(512, 512, 512);
		send_unused();
		send_read(0);
		send_read(VERTEX_COUNT - 1);
		send_read(512);
		send_read(341);
		send_load(0, '0, '0, '0);
		send_triangle(0, VERTEX_COUNT - 1, 341);
		send_read(0);
	endtask

	// Two copies of a maximal triangle, one wound each way, build large sums
	// of both signs in every component of six accumulators.
	task automatic test_large_sums();
		idle_pct = 0;
		stall_pct = 10;
		for (int k = 0; k < 2; k++) begin
			send_load(BIG_BASE + 3 * k, COORD_MIN, COORD_MIN, COORD_MIN);
			send_load(BIG_BASE + 3 * k + 1, COORD_MAX, COORD_MAX, COORD_MIN);
			send_load(BIG_BASE + 3 * k + 2, COORD_MIN, COORD_MAX, COORD_MAX);
		end
		for (int n = 0; n < BIG_ROUNDS; n++) begin
			send_triangle(BIG_BASE, BIG_BASE + 1, BIG_BASE + 2);
			send_triangle(BIG_BASE + 3, BIG_BASE + 5, BIG_BASE + 4);
			if (n % 32 == 31) begin
				send_read(BIG_BASE);
				send_read(BIG_BASE + 4);
			end
		end
		for (int k = 0; k < 6; k++)
			send_read(BIG_BASE + k);
		// Opposite winding takes one triangle's worth back off each sum.
		send_triangle(BIG_BASE, BIG_BASE + 2, BIG_BASE + 1);
		send_read(BIG_BASE);
		send_read(BIG_BASE + 1);
	endtask

	task automatic test_random_mesh();
		int base;
		int pick;
		base = 0;
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 100 == 0) begin
				base = $urandom_range(0, VERTEX_COUNT - 16);
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 15;
					default: idle_pct = 40;
				endcase
				stall_pct = idle_pct;
			end
			if (n >= RANDOM_BEATS - CALM_BEATS) begin
				idle_pct = 0;
				stall_pct = 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				if ($urandom_range(0, 4) < 3)
					send_load(base + $urandom_range(0, 15), rand_coord(), rand_coord(),
						rand_coord());
				else
					send_load(rand_index(), rand_coord(), rand_coord(), rand_coord());
			end else if (pick < 65) begin
				send_triangle(pick_corner(base), pick_corner(base), pick_corner(base));
			end else if (pick < 95) begin
				if ($urandom_range(0, 9) < 7)
					send_read(pick_corner(base));
				else
					send_read(rand_index());
			end else begin
				send_unused();
			end
		end
	endtask

	initial begin
		for (int i = 0; i < VERTEX_COUNT; i++) begin
			sum_x[i] = '0;
			sum_y[i] = '0;
			sum_z[i] = '0;
		end
		in_valid <= 1'b0;
		op <= OP_NONE;
		index_a <= '0;
		index_b <= '0;
		index_c <= '0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_cleared_state();
		test_corner_mesh();
		test_large_sums();
		test_random_mesh();

		in_valid <= 1'b0;
		while (pending_normals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Output side holds off in random bursts while stall_pct is nonzero.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	function automatic void check_component(string name, logic signed [ACCUM_BITS-1:0] want,
			logic signed [ACCUM_BITS-1:0] got);
		if (got !== want) begin
			failures++;
			$error("%s: expected %0d, got %0d", name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		normal_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_normals.size() == 0) begin
				failures++;
				$error("normal beat with no readout pending: %0d %0d %0d",
					normal_x, normal_y, normal_z);
			end else begin
				want = pending_normals.pop_front();
				check_component("normal_x", want.x, normal_x);
				check_component("normal_y", want.y, normal_y);
				check_component("normal_z", want.z, normal_z);
			end
		end
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/vnacc_pkg.sv
rtl/vnacc_ram.sv
rtl/vnacc_ctrl.sv
rtl/vnacc_datapath.sv
rtl/vertex_normal_accumulator_unit.sv
rtl/vnacc_checker.sv
tb/tb_vertex_normal_accumulator_unit.sv
